@@ rtl/core/cau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants of the complex arithmetic unit
// Operation and status codes, fixed-point widths and the pipeline word types.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;        // one full product
  localparam int SUM_W     = PROD_W + 1;        // sum of two products
  localparam int NUM_W     = SUM_W + FRAC_BITS; // shifted dividend
  localparam int CMP_W     = (NUM_W > PROD_W + DATA_W) ? NUM_W : PROD_W + DATA_W;
  localparam int DIV_STEPS = DATA_W;            // one quotient bit a stage

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cau_op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  // Side information that travels beside the divider lanes.
  typedef struct packed {
    cau_op_t           op;
    logic              zero_den;
    logic              neg_re;
    logic              neg_im;
    logic              big_re;   // quotient already known to need 33 bits or more
    logic              big_im;
    logic [DATA_W-1:0] fast_re;  // add, subtract and multiply results
    logic [DATA_W-1:0] fast_im;
    logic              fast_ovf;
  } cau_side_t;

  // One word of the divider pipeline.
  typedef struct packed {
    logic              vld;
    cau_side_t         side;
    logic [PROD_W-1:0] den;
    logic [PROD_W-1:0] rem_re;
    logic [PROD_W-1:0] rem_im;
    logic [DATA_W-1:0] qd_re;    // dividend bits out, quotient bits in
    logic [DATA_W-1:0] qd_im;
  } cau_dstage_t;

endpackage

@@ rtl/core/cau_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_in_if / cau_out_if: operand and result channels
// Valid/ready channels carrying one word of operands or of results.
// ----------------------------------------------------------------------------
interface cau_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  operation;
  logic signed [31:0] a_real;
  logic signed [31:0] a_imag;
  logic signed [31:0] b_real;
  logic signed [31:0] b_imag;

  modport source (output valid, operation, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, operation, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_real;
  logic signed [31:0] res_imag;
  logic        [1:0]  status;

  modport source (output valid, res_real, res_imag, status, input ready);
  modport sink   (input valid, res_real, res_imag, status, output ready);
endinterface

@@ rtl/core/cau_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front: operand register, products, sums and divider set-up
// Four stages: capture, six products, product sums, then the add, subtract
// and multiply results plus the dividend magnitude for the divider.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [1:0]                operation,
  input  logic signed [31:0]        a_real,
  input  logic signed [31:0]        a_imag,
  input  logic signed [31:0]        b_real,
  input  logic signed [31:0]        b_imag,
  output cau_pkg::cau_dstage_t      d_o
);
  import cau_pkg::*;

  // Stage 1: operand capture.
  logic                     v1_r;
  cau_op_t                  op1_r;
  logic signed [DATA_W-1:0] ar_r, ai_r, br_r, bi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
    end
    if (en) begin
      op1_r <= cau_op_t'(operation);
      ar_r  <= a_real;
      ai_r  <= a_imag;
      br_r  <= b_real;
      bi_r  <= b_imag;
    end
  end

  // Stage 2: all products, and add or subtract saturated.
  logic signed [DATA_W:0]   as_sum;
  logic [DATA_W-1:0]        as_re, as_im;
  logic                     as_ovf;
  logic signed [DATA_W:0]   s_re, s_im;

  always_comb begin
    if (op1_r == OP_SUB) begin
      s_re = (DATA_W+1)'(ar_r) - (DATA_W+1)'(br_r);
      s_im = (DATA_W+1)'(ai_r) - (DATA_W+1)'(bi_r);
    end else begin
      s_re = (DATA_W+1)'(ar_r) + (DATA_W+1)'(br_r);
      s_im = (DATA_W+1)'(ai_r) + (DATA_W+1)'(bi_r);
    end
    as_ovf = 1'b0;
    as_sum = s_re;
    if (as_sum[DATA_W] != as_sum[DATA_W-1]) begin
      as_re  = as_sum[DATA_W] ? SAT_NEG : SAT_POS;
      as_ovf = 1'b1;
    end else begin
      as_re = as_sum[DATA_W-1:0];
    end
    if (s_im[DATA_W] != s_im[DATA_W-1]) begin
      as_im  = s_im[DATA_W] ? SAT_NEG : SAT_POS;
      as_ovf = 1'b1;
    end else begin
      as_im = s_im[DATA_W-1:0];
    end
  end

  logic                     v2_r;
  cau_op_t                  op2_r;
  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_cc_r;
  logic [DATA_W-1:0]        as_re2_r, as_im2_r;
  logic                     as_ovf2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      op2_r     <= op1_r;
      p_rr_r    <= ar_r * br_r;
      p_ii_r    <= ai_r * bi_r;
      p_ri_r    <= ar_r * bi_r;
      p_ir_r    <= ai_r * br_r;
      p_bb_r    <= br_r * br_r;
      p_cc_r    <= bi_r * bi_r;
      as_re2_r  <= as_re;
      as_im2_r  <= as_im;
      as_ovf2_r <= as_ovf;
    end
  end

  // Stage 3: product sums for multiply and divide, and the divisor.
  logic                    v3_r;
  cau_op_t                 op3_r;
  logic signed [SUM_W-1:0] pr_r, pi_r, nr_r, ni_r;
  logic [PROD_W-1:0]       den_r;
  logic [DATA_W-1:0]       as_re3_r, as_im3_r;
  logic                    as_ovf3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      op3_r     <= op2_r;
      pr_r      <= SUM_W'(p_rr_r) - SUM_W'(p_ii_r);
      pi_r      <= SUM_W'(p_ri_r) + SUM_W'(p_ir_r);
      nr_r      <= SUM_W'(p_rr_r) + SUM_W'(p_ii_r);
      ni_r      <= SUM_W'(p_ir_r) - SUM_W'(p_ri_r);
      den_r     <= PROD_W'(p_bb_r) + PROD_W'(p_cc_r);
      as_re3_r  <= as_re2_r;
      as_im3_r  <= as_im2_r;
      as_ovf3_r <= as_ovf2_r;
    end
  end

  // Stage 4: multiply scaling, dividend magnitude and the early overflow test.
  logic signed [SUM_W-1:0] sh_re, sh_im;
  logic [DATA_W-1:0]       mul_re, mul_im;
  logic                    mul_ovf;
  logic signed [NUM_W-1:0] num_re, num_im;
  logic [NUM_W-1:0]        mag_re, mag_im;
  logic [CMP_W-1:0]        den_hi;
  cau_dstage_t             d_nxt;

  always_comb begin
    sh_re   = pr_r >>> FRAC_BITS;
    sh_im   = pi_r >>> FRAC_BITS;
    mul_ovf = 1'b0;
    if (sh_re[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){sh_re[SUM_W-1]}}) begin
      mul_re  = sh_re[SUM_W-1] ? SAT_NEG : SAT_POS;
      mul_ovf = 1'b1;
    end else begin
      mul_re = sh_re[DATA_W-1:0];
    end
    if (sh_im[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){sh_im[SUM_W-1]}}) begin
      mul_im  = sh_im[SUM_W-1] ? SAT_NEG : SAT_POS;
      mul_ovf = 1'b1;
    end else begin
      mul_im = sh_im[DATA_W-1:0];
    end

    num_re = NUM_W'(nr_r) <<< FRAC_BITS;
    num_im = NUM_W'(ni_r) <<< FRAC_BITS;
    mag_re = num_re[NUM_W-1] ? NUM_W'(-num_re) : NUM_W'(num_re);
    mag_im = num_im[NUM_W-1] ? NUM_W'(-num_im) : NUM_W'(num_im);
    den_hi = CMP_W'({den_r, {DATA_W{1'b0}}});

    d_nxt               = '0;
    d_nxt.vld           = v3_r;
    d_nxt.side.op       = op3_r;
    d_nxt.side.zero_den = (den_r == '0);
    d_nxt.side.neg_re   = nr_r[SUM_W-1];
    d_nxt.side.neg_im   = ni_r[SUM_W-1];
    d_nxt.side.big_re   = (CMP_W'(mag_re) >= den_hi);
    d_nxt.side.big_im   = (CMP_W'(mag_im) >= den_hi);
    if (op3_r == OP_MUL) begin
      d_nxt.side.fast_re  = mul_re;
      d_nxt.side.fast_im  = mul_im;
      d_nxt.side.fast_ovf = mul_ovf;
    end else begin
      d_nxt.side.fast_re  = as_re3_r;
      d_nxt.side.fast_im  = as_im3_r;
      d_nxt.side.fast_ovf = as_ovf3_r;
    end
    d_nxt.den    = den_r;
    d_nxt.rem_re = PROD_W'(mag_re >> DATA_W);
    d_nxt.rem_im = PROD_W'(mag_im >> DATA_W);
    d_nxt.qd_re  = mag_re[DATA_W-1:0];
    d_nxt.qd_im  = mag_im[DATA_W-1:0];
  end

  cau_dstage_t d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r.vld <= d_nxt.vld;
    end
    if (en) begin
      d_r.side   <= d_nxt.side;
      d_r.den    <= d_nxt.den;
      d_r.rem_re <= d_nxt.rem_re;
      d_r.rem_im <= d_nxt.rem_im;
      d_r.qd_re  <= d_nxt.qd_re;
      d_r.qd_im  <= d_nxt.qd_im;
    end
  end

  assign d_o = d_r;

endmodule

@@ rtl/core/cau_div_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div_step: one restoring division stage for both lanes
// Shifts one dividend bit into each remainder, subtracts the divisor where
// it fits and shifts the resulting quotient bit in.
// ----------------------------------------------------------------------------
module cau_div_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  cau_pkg::cau_dstage_t d_i,
  output cau_pkg::cau_dstage_t d_o
);
  import cau_pkg::*;

  logic [PROD_W:0]   t_re, t_im;
  logic              q_re, q_im;
  logic [PROD_W-1:0] rem_re_nxt, rem_im_nxt;

  // Trial subtraction in each lane.
  always_comb begin
    t_re = {d_i.rem_re, d_i.qd_re[DATA_W-1]};
    t_im = {d_i.rem_im, d_i.qd_im[DATA_W-1]};
    q_re = (t_re >= {1'b0, d_i.den});
    q_im = (t_im >= {1'b0, d_i.den});
    rem_re_nxt = q_re ? PROD_W'(t_re - {1'b0, d_i.den}) : PROD_W'(t_re);
    rem_im_nxt = q_im ? PROD_W'(t_im - {1'b0, d_i.den}) : PROD_W'(t_im);
  end

  cau_dstage_t d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r.vld <= d_i.vld;
    end
    if (en) begin
      d_r.side   <= d_i.side;
      d_r.den    <= d_i.den;
      d_r.rem_re <= rem_re_nxt;
      d_r.rem_im <= rem_im_nxt;
      d_r.qd_re  <= {d_i.qd_re[DATA_W-2:0], q_re};
      d_r.qd_im  <= {d_i.qd_im[DATA_W-2:0], q_im};
    end
  end

  assign d_o = d_r;

endmodule

@@ rtl/core/cau_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_back: quotient sign, saturation and the output register
// Applies the dividend sign to each quotient, clamps it, picks the result
// of the operation and forms the status.
// ----------------------------------------------------------------------------
module cau_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  cau_pkg::cau_dstage_t d_i,
  output logic                 vld_o,
  output logic [31:0]          re_o,
  output logic [31:0]          im_o,
  output logic [1:0]           status_o
);
  import cau_pkg::*;

  logic [DATA_W-1:0] q_re, q_im, re_nxt, im_nxt;
  logic              ovf_re, ovf_im;
  logic [1:0]        st_nxt;

  // Signed quotient with saturation, one lane each.
  always_comb begin
    if (d_i.side.neg_re) begin
      ovf_re = d_i.side.big_re || (d_i.qd_re > SAT_NEG);
      q_re   = ovf_re ? SAT_NEG : DATA_W'(-d_i.qd_re);
    end else begin
      ovf_re = d_i.side.big_re || d_i.qd_re[DATA_W-1];
      q_re   = ovf_re ? SAT_POS : d_i.qd_re;
    end
    if (d_i.side.neg_im) begin
      ovf_im = d_i.side.big_im || (d_i.qd_im > SAT_NEG);
      q_im   = ovf_im ? SAT_NEG : DATA_W'(-d_i.qd_im);
    end else begin
      ovf_im = d_i.side.big_im || d_i.qd_im[DATA_W-1];
      q_im   = ovf_im ? SAT_POS : d_i.qd_im;
    end

    if (d_i.side.op == OP_DIV) begin
      if (d_i.side.zero_den) begin
        re_nxt = '0;
        im_nxt = '0;
        st_nxt = ST_DIV0;
      end else begin
        re_nxt = q_re;
        im_nxt = q_im;
        st_nxt = (ovf_re || ovf_im) ? ST_OVF : ST_OK;
      end
    end else begin
      re_nxt = d_i.side.fast_re;
      im_nxt = d_i.side.fast_im;
      st_nxt = d_i.side.fast_ovf ? ST_OVF : ST_OK;
    end
  end

  logic              vld_r;
  logic [DATA_W-1:0] re_r, im_r;
  logic [1:0]        st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= d_i.vld;
    end
    if (en) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
      st_r <= st_nxt;
    end
  end

  assign vld_o    = vld_r;
  assign re_o     = re_r;
  assign im_o     = im_r;
  assign status_o = st_r;

endmodule

@@ rtl/core/complex_arith_unit_top.sv @@
`timescale 1ns / 1ps
// Each operand word passes the front, divider and output registers in order.
// Throughput: one word per cycle; the 32-stage restoring divider, one
// quotient bit per stage, sets the depth of the pipeline.
// A stall at the output holds the whole pipeline in place.
// Reset (rst_n low, synchronous) clears all valid bits; the pipe starts empty.
// ----------------------------------------------------------------------------
// complex_arith_unit_top: pipelined complex ALU on signed Q16.16 operands
// Add, subtract, multiply and divide with saturation and status.
// ----------------------------------------------------------------------------
module complex_arith_unit_top (
  input  logic  clk,
  input  logic  rst_n,
  cau_in_if.sink    in_ch,
  cau_out_if.source out_ch
);
  import cau_pkg::*;

  logic en;
  logic out_vld;
  logic [DATA_W-1:0] out_re, out_im;
  logic [1:0] out_st;

  // The pipe advances whenever the output register is free or being taken.
  assign en = !out_vld || out_ch.ready;
  assign in_ch.ready = en;

  cau_dstage_t chain [DIV_STEPS+1];

  cau_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_ch.valid),
    .operation (in_ch.operation),
    .a_real    (in_ch.a_real),
    .a_imag    (in_ch.a_imag),
    .b_real    (in_ch.b_real),
    .b_imag    (in_ch.b_imag),
    .d_o       (chain[0])
  );

  // Divider stages, one quotient bit each.
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    cau_div_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (chain[g]),
      .d_o   (chain[g+1])
    );
  end

  cau_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .d_i      (chain[DIV_STEPS]),
    .vld_o    (out_vld),
    .re_o     (out_re),
    .im_o     (out_im),
    .status_o (out_st)
  );

  assign out_ch.valid    = out_vld;
  assign out_ch.res_real = out_re;
  assign out_ch.res_imag = out_im;
  assign out_ch.status   = out_st;

  // A waiting word blocks new input.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while the output word is stalled");

  // A zero divisor always yields zero components.
  a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && out_st == ST_DIV0) |-> (out_re == '0 && out_im == '0))
    else $error("divide by zero word carries non-zero components");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_vld)
    else $error("output valid straight after reset");

  // A word at the divider output is never lost when the output register is free.
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (chain[DIV_STEPS].vld && en) |=> out_vld)
    else $error("divider word dropped at the output register");

endmodule

@@ tb/sv/complex_arith_unit_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arith_unit_top_tb: self-checking bench for the complex ALU
// Directed corner words and random operand words are sent through the
// operand channel; a bit-accurate predictor computes each result word,
// which is compared field by field with the words leaving the unit.
// ----------------------------------------------------------------------------
module complex_arith_unit_top_tb;
  import cau_pkg::*;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  st;
  } cau_result_t;

  localparam int LATENCY   = 37;
  localparam int CYCLE_CAP = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cau_in_if  in_ch ();
  cau_out_if out_ch ();

  complex_arith_unit_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  cau_result_t expected_q[$];
  int          err_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Guard against a hung pipeline.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("complex_arith_unit_top test failed");
      $finish;
    end
  end

  // Clamp a wide signed value to 32 bits, flagging overflow.
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return SAT_POS;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return SAT_NEG;
    end
    return v[31:0];
  endfunction

  // Signed division truncating toward zero (SystemVerilog / does that).
  function automatic logic [31:0] quotient32(input logic signed [127:0] num,
                                             input logic signed [127:0] den,
                                             inout logic ovf);
    logic signed [127:0] q;
    q = num / den;
    return clamp32(q, ovf);
  endfunction

  // Predict one result word from one operand word.
  function automatic cau_result_t predict_complex(input cau_op_t op,
      input logic signed [31:0] ar, input logic signed [31:0] ai,
      input logic signed [31:0] br, input logic signed [31:0] bi);
    cau_result_t r;
    logic ovf;
    logic signed [127:0] xr, xi, xbr, xbi, pr, pi, den;
    ovf = 1'b0;
    r = '0;
    xr = ar;
    xi = ai;
    xbr = br;
    xbi = bi;
    case (op)
      OP_ADD: begin
        r.re = clamp32(xr + xbr, ovf);
        r.im = clamp32(xi + xbi, ovf);
      end
      OP_SUB: begin
        r.re = clamp32(xr - xbr, ovf);
        r.im = clamp32(xi - xbi, ovf);
      end
      OP_MUL: begin
        pr = xr * xbr - xi * xbi;
        pi = xr * xbi + xi * xbr;
        r.re = clamp32(pr >>> FRAC_BITS, ovf);
        r.im = clamp32(pi >>> FRAC_BITS, ovf);
      end
      default: begin
        den = xbr * xbr + xbi * xbi;
        if (den == 0) begin
          r.st = ST_DIV0;
        end else begin
          pr = (xr * xbr + xi * xbi) <<< FRAC_BITS;
          pi = (xi * xbr - xr * xbi) <<< FRAC_BITS;
          r.re = quotient32(pr, den, ovf);
          r.im = quotient32(pi, den, ovf);
        end
      end
    endcase
    if (r.st == ST_OK && ovf) r.st = ST_OVF;
    return r;
  endfunction

  // Send one operand word and record its predicted result. Valid stays high
  // after the accepting edge; the next idle cycle or the next word sets it.
  task automatic send_word(input cau_op_t op, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.a_real    <= ar;
    in_ch.a_imag    <= ai;
    in_ch.b_real    <= br;
    in_ch.b_imag    <= bi;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(predict_complex(op, ar, ai, br, bi));
  endtask

  // Random 32-bit operand with a bias towards edges and small magnitudes.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return SAT_POS;
      1: return SAT_NEG;
      2: return 32'($signed($urandom_range(131072)) - 65536);
      3: return '0;
      4: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
      default: return $urandom;
    endcase
  endfunction

  // Result side: random stalls and field-by-field comparison.
  always @(posedge clk) begin
    cau_result_t exp_w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word re=%h im=%h st=%0d", $time,
                   out_ch.res_real, out_ch.res_imag, out_ch.status);
          err_count++;
        end else begin
          exp_w = expected_q.pop_front();
          if (exp_w.re !== out_ch.res_real) begin
            $display("%0t: res_real expected %h actual %h", $time, exp_w.re, out_ch.res_real);
            err_count++;
          end
          if (exp_w.im !== out_ch.res_imag) begin
            $display("%0t: res_imag expected %h actual %h", $time, exp_w.im, out_ch.res_imag);
            err_count++;
          end
          if (exp_w.st !== out_ch.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_w.st, out_ch.status);
            err_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stop sending and wait until every expected word has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Extremes of every field, every operation, saturation and zero divisor.
  task automatic test_directed();
    send_word(OP_ADD, SAT_POS, SAT_NEG, 32'd1, 32'hFFFF_FFFF);
    send_word(OP_ADD, SAT_NEG, SAT_POS, SAT_NEG, SAT_POS);
    send_word(OP_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
    send_word(OP_SUB, SAT_NEG, SAT_POS, 32'd1, 32'hFFFF_FFFF);
    send_word(OP_SUB, SAT_POS, SAT_NEG, SAT_NEG, SAT_POS);
    send_word(OP_SUB, 32'h0, 32'h0, 32'h0, 32'h0);
    send_word(OP_MUL, 32'h0001_0000, 32'h0, 32'h0002_8000, 32'hFFFE_0000);
    send_word(OP_MUL, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG);
    send_word(OP_MUL, SAT_POS, SAT_POS, SAT_POS, SAT_NEG);
    send_word(OP_MUL, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1);
    send_word(OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
    send_word(OP_DIV, SAT_POS, SAT_NEG, 32'h0, 32'h0);
    send_word(OP_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0002_0000, 32'h0);
    send_word(OP_DIV, SAT_POS, SAT_POS, 32'd1, 32'd0);
    send_word(OP_DIV, SAT_NEG, SAT_NEG, 32'd0, 32'd1);
    send_word(OP_DIV, SAT_NEG, SAT_POS, SAT_NEG, SAT_NEG);
    send_word(OP_DIV, 32'hFFFF_FFFF, 32'd3, SAT_POS, SAT_POS);
    send_word(OP_DIV, 32'h8000_0000, 32'h0, 32'hFFFF_0000, 32'h0);
  endtask

  // Random words under a given idling pattern.
  task automatic test_random(input int count, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count)
      send_word(cau_op_t'($urandom_range(3)), pick_operand(), pick_operand(),
                pick_operand(), pick_operand());
  endtask

  // The sender holds off until every result has come back.
  task automatic test_drain_pause();
    send_idle_pct = 0;
    recv_idle_pct = 20;
    wait_drained();
    repeat (5)
      send_word(cau_op_t'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_ADD;
    in_ch.a_real    <= '0;
    in_ch.a_imag    <= '0;
    in_ch.b_real    <= '0;
    in_ch.b_imag    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 31;
    recv_idle_pct = 68;
    test_directed();
    test_random(380, 31, 68);
    test_random(380, 68, 31);
    test_drain_pause();
    test_random(380, 0, 0);
    recv_idle_pct = 30;
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("complex_arith_unit_top test passed");
    end else begin
      $display("complex_arith_unit_top test failed");
    end
    $finish;
  end

endmodule
